// ----- hw/rtl/efr_pkg.sv -----
// ----------------------------------------------------------------------------
// efr_pkg
// Shared types and constants for the escaped frame receiver with CRC-32 check.
// ----------------------------------------------------------------------------
package efr_pkg;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned CRC_W   = 32;

  // Link control bytes
  localparam logic [BYTE_W-1:0] ESC_BYTE    = 8'h18;
  localparam logic [BYTE_W-1:0] CMD_START   = 8'h50;  // 'P'
  localparam logic [BYTE_W-1:0] CMD_END     = 8'h46;  // 'F'
  localparam logic [BYTE_W-1:0] CMD_LITERAL = 8'h58;  // 'X'

  // Packet checks
  localparam logic [CNT_W-1:0] MIN_HELD        = 11'd4;
  localparam logic [CRC_W-1:0] CRC_POLY        = 32'hEDB88320;
  localparam logic [CRC_W-1:0] CRC_INIT        = 32'hFFFFFFFF;
  // Running value before final inversion; inverted it is 0x2144DF1C
  localparam logic [CRC_W-1:0] CRC_RESIDUE_RAW = 32'hDEBB20E3;

  // Register map
  localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;
  localparam logic             REG_CAPACITY = 1'b0;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_PACKET = 2'd1,
    ST_FAIL   = 2'd2
  } status_t;

  // One result beat
  typedef struct packed {
    status_t           status;
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_value;
    logic [IDX_W-1:0]  byte_index;
    logic [CNT_W-1:0]  frame_length;
  } res_t;

endpackage

// ----- hw/rtl/efr_crc_byte.sv -----
// ----------------------------------------------------------------------------
// efr_crc_byte
// Bytewise update of the reflected CRC-32 (polynomial 0xEDB88320).
// ----------------------------------------------------------------------------
module efr_crc_byte (
  input  logic [efr_pkg::CRC_W-1:0]  crc_in,
  input  logic [efr_pkg::BYTE_W-1:0] data,
  output logic [efr_pkg::CRC_W-1:0]  crc_out
);

  // Eight shift steps, LSB first
  always_comb begin
    logic [efr_pkg::CRC_W-1:0] c;
    c = crc_in ^ {{(efr_pkg::CRC_W-efr_pkg::BYTE_W){1'b0}}, data};
    for (int k = 0; k < efr_pkg::BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ efr_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

// ----- hw/rtl/efr_deframer.sv -----
// ----------------------------------------------------------------------------
// efr_deframer
// Unstuffing state machine: escape flag, byte count and running CRC, and
// the result for each byte taken from the input stage.
// ----------------------------------------------------------------------------
module efr_deframer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [efr_pkg::BYTE_W-1:0] rx_byte,
  input  logic [efr_pkg::CNT_W-1:0]  limit,
  output efr_pkg::res_t              res
);

  logic                       escape_pending, escape_pending_next;
  logic [efr_pkg::CNT_W-1:0]  byte_count, byte_count_next;
  logic [efr_pkg::CRC_W-1:0]  crc_register, crc_register_next;
  logic [efr_pkg::BYTE_W-1:0] store_data;
  logic [efr_pkg::CRC_W-1:0]  crc_fed;

  // Escaped 'X' stores a literal escape byte
  assign store_data = escape_pending ? efr_pkg::ESC_BYTE : rx_byte;

  efr_crc_byte u_crc (
    .crc_in  (crc_register),
    .data    (store_data),
    .crc_out (crc_fed)
  );

  // Decode one byte
  always_comb begin
    logic do_store;
    logic do_fail;
    do_store            = 1'b0;
    do_fail             = 1'b0;
    escape_pending_next = 1'b0;
    byte_count_next     = byte_count;
    crc_register_next   = crc_register;
    res                 = '0;
    res.status          = efr_pkg::ST_OK;

    priority if (escape_pending) begin
      priority if (rx_byte == efr_pkg::CMD_START) begin
        byte_count_next   = '0;
        crc_register_next = efr_pkg::CRC_INIT;
      end else if (rx_byte == efr_pkg::CMD_END) begin
        if (byte_count < efr_pkg::MIN_HELD ||
            crc_register != efr_pkg::CRC_RESIDUE_RAW) begin
          do_fail = 1'b1;
        end else begin
          res.status       = efr_pkg::ST_PACKET;
          res.frame_length = byte_count;
        end
      end else if (rx_byte == efr_pkg::CMD_LITERAL) begin
        do_store = 1'b1;
      end else begin
        do_fail = 1'b1;
      end
    end else if (rx_byte == efr_pkg::ESC_BYTE) begin
      escape_pending_next = 1'b1;
    end else begin
      do_store = 1'b1;
    end

    // Store path, with overflow check
    if (do_store) begin
      if (byte_count >= limit) begin
        do_fail = 1'b1;
      end else begin
        crc_register_next = crc_fed;
        byte_count_next   = byte_count + 1'b1;
        res.byte_valid    = 1'b1;
        res.byte_value    = store_data;
        res.byte_index    = byte_count[efr_pkg::IDX_W-1:0];
      end
    end

    // Any failure drops the packet so far
    if (do_fail) begin
      res.status        = efr_pkg::ST_FAIL;
      byte_count_next   = '0;
      crc_register_next = efr_pkg::CRC_INIT;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      byte_count     <= '0;
      crc_register   <= efr_pkg::CRC_INIT;
    end else if (advance) begin
      escape_pending <= escape_pending_next;
      byte_count     <= byte_count_next;
      crc_register   <= crc_register_next;
    end
  end

endmodule

// ----- hw/rtl/escaped_frame_receiver_crc32_core.sv -----
// ----------------------------------------------------------------------------
// escaped_frame_receiver_crc32_core
// Byte-stuffed link receiver: undoes escape coding, streams stored bytes
// with their index and checks the CRC-32 residue at each packet end.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  in        in_valid/in_ready    rx_byte
//  out       out_valid/out_ready  status, byte_valid, byte_value, byte_index,
//                                 frame_length
//  cfg       APB psel/penable     capacity at 0x0 (11 bits)
//
// One byte per cycle sustained while out_ready holds. A beat is registered in
// the input stage and then decoded into the result register.
// The decode stage moves whenever the result register is empty or taken, so
// on a stalled output input is taken only while the input stage is empty.
// rst is synchronous: clears the escape flag and count, sets the CRC to its
// initial value, and sets capacity to 1024.
// ----------------------------------------------------------------------------
module escaped_frame_receiver_crc32_core #(
  parameter int unsigned BUFFER_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // Config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  // Output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        byte_valid,
  output logic [7:0]  byte_value,
  output logic [9:0]  byte_index,
  output logic [10:0] frame_length
);

  localparam int unsigned CNT_MAX = (1 << efr_pkg::CNT_W) - 1;
  localparam int unsigned BUF_LIM = (BUFFER_BYTES > CNT_MAX) ? CNT_MAX : BUFFER_BYTES;

  logic [efr_pkg::CNT_W-1:0]  capacity;
  logic [efr_pkg::CNT_W-1:0]  limit;
  logic                       s1_valid;
  logic [efr_pkg::BYTE_W-1:0] s1_byte;
  logic                       advance;
  efr_pkg::res_t              res;
  efr_pkg::res_t              out_res;

  // Config register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == efr_pkg::REG_CAPACITY) ?
                  {{(32-efr_pkg::CNT_W){1'b0}}, capacity} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= efr_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == efr_pkg::REG_CAPACITY) begin
      capacity <= pwdata[efr_pkg::CNT_W-1:0];
    end
  end

  // Limit in force: smaller of capacity and buffer size
  assign limit = (capacity < efr_pkg::CNT_W'(BUF_LIM)) ? capacity
                                                       : efr_pkg::CNT_W'(BUF_LIM);

  // Handshake between stages
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

  efr_deframer u_deframer (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .rx_byte (s1_byte),
    .limit   (limit),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign status       = out_res.status;
  assign byte_valid   = out_res.byte_valid;
  assign byte_value   = out_res.byte_value;
  assign byte_index   = out_res.byte_index;
  assign frame_length = out_res.frame_length;

  // Checks
  a_store_is_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> status == efr_pkg::ST_OK)
    else $error("stored byte reported with non-ok status");

  a_len_only_on_packet: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_length != '0 |-> status == efr_pkg::ST_PACKET)
    else $error("packet length outside a good packet end");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_byte))
    else $error("input stage lost or changed a stalled beat");

endmodule
